[rtl/eabb_pkg.sv]
package eabb_pkg;

    // Line store depth and the widths that follow from it.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);

    // Number of channels carried per pixel; channel 0 is the height byte.
    localparam int CHANNELS = 4;
    localparam logic [23:0] EXTRA_MASK =
        (CHANNELS >= 4) ? 24'hFF_FFFF :
        (CHANNELS <= 1) ? 24'h00_0000 :
        24'((32'd1 << (8 * (CHANNELS - 1))) - 32'd1);

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd1024;

    // Mean by reciprocal multiply: q = (sum * recip) >> DIV_SHIFT.
    // The sum stays below 2304, so the rounded-up reciprocals are exact.
    localparam int SUM_W     = 12;
    localparam int RECIP_W   = 15;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int DIV_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_DIV4 = 15'd16384;
    localparam logic [RECIP_W-1:0] RECIP_DIV6 = 15'd10923;
    localparam logic [RECIP_W-1:0] RECIP_DIV9 = 15'd7282;

endpackage

[rtl/edge_aware_box_blur_3x3_core.sv]
// Edge-aware 3x3 box blur on a raster-order pixel stream. Each input word
// carries an 8-bit height and the other channel bytes; each result word
// carries the truncated mean of the in-frame 3x3 neighbourhood of one pixel
// (divided by 4 in a corner, 6 on an edge, 9 inside) together with that
// pixel's other channel bytes, unchanged. Results trail the input by one
// row plus one pixel, so at the end of a frame the user sends drain words
// (op = 1) to push the pending results out; the result for the frame's
// final pixel carries last_of_frame, and the next word starts a new frame.
// Drain words sent before all pixels of a frame are in are discarded, and
// a pixel sent while draining counts as a drain. If the effective width or
// height is at most 2, each pixel comes straight back as its own result and
// drain words are discarded. The block sustains one word per clock while
// the output is not stalled: the two line stores are single memories
// doing one read and one write per cycle, and within a frame the
// read-modify-write of any column is spaced at least three words apart,
// so no interlock is needed. The one overlap is at a frame boundary, where
// the first word of the new frame may read column 0 while the old frame's
// final word is still writing it; that read only feeds the rows above the
// frame, which are masked. A result reaches the output register through
// three register stages (memory read, neighbourhood sum, reciprocal
// multiply) after the word that releases it is accepted.
// Writing frame_width or frame_height restarts the frame and must only be
// done while the block is idle; a write to any other index is ignored.
// There is no clearing pass after reset: stale line entries only ever feed
// neighbours that lie outside the frame.
module edge_aware_box_blur_3x3_core
    import eabb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input word channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_op,
    input  logic [7:0]           i_height_value,
    input  logic [23:0]          i_extra_channels,
    // result word channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_smoothed_value,
    output logic [23:0]          o_extra_channels_out,
    output logic                 o_last_of_frame,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wr_data
);

    // ------------------------------------------------------------------
    // Configuration and frame position counters
    // ------------------------------------------------------------------
    // The input row runs one past the last drain row, so it needs a bit
    // more than the height register.
    logic [10:0]      r_frame_width;
    logic [15:0]      r_frame_height;
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [16:0]      r_in_row, n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [15:0]      r_out_row, n_out_row;

    logic [31:0]      w_raw;
    logic [WID_W-1:0] w_eff;
    logic [15:0]      h_eff;
    logic             pass_mode;
    logic             cfg_hit;

    always_comb begin
        w_raw = 32'(r_frame_width);
        if (w_raw == 32'd0) begin
            w_raw = 32'd1;
        end else if (w_raw > 32'(MAX_WIDTH)) begin
            w_raw = 32'(MAX_WIDTH);
        end
    end

    assign w_eff     = WID_W'(w_raw);
    assign h_eff     = (r_frame_height == 16'd0) ? 16'd1 : r_frame_height;
    assign pass_mode = (w_eff <= WID_W'(2)) || (h_eff <= 16'd2);
    assign cfg_hit   = i_cfg_wr_en &&
                       (i_cfg_index == CFG_FRAME_WIDTH ||
                        i_cfg_index == CFG_FRAME_HEIGHT);

    // ------------------------------------------------------------------
    // Pipeline flow control: every stage moves when the one after it has
    // room, so an empty stage fills even while a result waits at the output.
    // ------------------------------------------------------------------
    logic r_b_valid, r_c_valid, r_out_valid;
    logic en_out, en_c, en_b, acc;

    assign en_out  = !r_out_valid || !i_stall;
    assign en_c    = !r_c_valid || en_out;
    assign en_b    = !r_b_valid || en_c;
    assign o_stall = !en_b || !i_rst_n;
    assign acc     = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Stage A: classify the word, work out its border flags and step the
    // counters. Normal-mode words issue the line store read here.
    // ------------------------------------------------------------------
    logic [WID_W-1:0] in_col_p1, out_col_p1;
    logic [16:0]      in_row_p1, out_row_p1;
    logic             in_beyond, norm_take, pass_take, emit_a;
    logic             pass_last, out_last, in_wrap, last_a;
    logic [7:0]       hv_a;
    logic [23:0]      ex_a;
    logic             top_ok_a, bot_ok_a, left_ok_a, right_ok_a;

    always_comb begin
        in_col_p1  = WID_W'(32'(r_in_col) + 32'd1);
        out_col_p1 = WID_W'(32'(r_out_col) + 32'd1);
        in_row_p1  = r_in_row + 17'd1;
        out_row_p1 = 17'(r_out_row) + 17'd1;

        // Past the last row every word is a drain carrying zero data.
        in_beyond = r_in_row >= 17'(h_eff);
        norm_take = !pass_mode && (in_beyond || !i_op);
        pass_take = pass_mode && !i_op;

        hv_a = in_beyond ? 8'd0 : i_height_value;
        ex_a = in_beyond ? 24'd0 : (i_extra_channels & EXTRA_MASK);

        emit_a    = (r_in_row >= 17'd2) || (r_in_row == 17'd1 && r_in_col != '0);
        in_wrap   = in_col_p1 >= w_eff;
        pass_last = in_wrap && (in_row_p1 >= 17'(h_eff));
        out_last  = (out_row_p1 == 17'(h_eff)) && (out_col_p1 == w_eff);
        last_a    = pass_mode ? pass_last : (emit_a && out_last);

        top_ok_a   = r_out_row != 16'd0;
        bot_ok_a   = out_row_p1 < 17'(h_eff);
        left_ok_a  = r_out_col != '0;
        right_ok_a = out_col_p1 < w_eff;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (acc && (pass_take || norm_take)) begin
            if (in_wrap) begin
                n_in_col = '0;
                n_in_row = in_row_p1;
            end else begin
                n_in_col = COL_W'(in_col_p1);
            end
            if (norm_take && emit_a && !out_last) begin
                if (out_col_p1 >= w_eff) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 16'd1;
                end else begin
                    n_out_col = COL_W'(out_col_p1);
                end
            end
            // The frame's final result restarts every counter.
            if (last_a) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_wr_data[10:0];
            end else begin
                r_frame_height <= i_cfg_wr_data[15:0];
            end
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. The row store keeps {newer row, older row} per column;
    // the pass-through store keeps the other channel bytes of the row
    // above. Read in stage A, written back when the word leaves stage B.
    // ------------------------------------------------------------------
    logic [15:0]      r_row_mem [MAX_WIDTH];
    logic [23:0]      r_pass_mem [MAX_WIDTH];
    logic [15:0]      r_rd_row;
    logic [23:0]      r_rd_pass;
    logic             rd_en, mem_we, b_go;
    logic [COL_W-1:0] r_b_addr;
    logic [7:0]       r_b_hv;
    logic [23:0]      r_b_ex;
    logic [7:0]       top_b, mid_b;

    assign rd_en  = acc && norm_take;
    assign b_go   = r_b_valid && en_c;
    assign top_b  = r_rd_row[7:0];
    assign mid_b  = r_rd_row[15:8];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row_mem[r_b_addr]  <= {r_b_hv, mid_b};
            r_pass_mem[r_b_addr] <= r_b_ex;
        end
        if (rd_en) begin
            r_rd_row  <= r_row_mem[r_in_col];
            r_rd_pass <= r_pass_mem[r_in_col];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: the 3x3 window is the two previous columns in registers
    // plus the column just read. Masked sum and choice of divisor.
    // ------------------------------------------------------------------
    logic       r_b_pass, r_b_emit, r_b_last;
    logic       r_b_top_ok, r_b_bot_ok, r_b_left_ok, r_b_right_ok;
    logic [7:0] r_win [6];
    logic [23:0] r_hold;

    logic [9:0]         left_sum, centre_sum, right_sum;
    logic [SUM_W-1:0]   sum_b;
    logic [RECIP_W-1:0] recip_b;
    logic               full_rows, full_cols;

    assign mem_we = b_go && !r_b_pass;

    always_comb begin
        left_sum   = (r_b_top_ok ? 10'(r_win[0]) : 10'd0) + 10'(r_win[1])
                   + (r_b_bot_ok ? 10'(r_win[2]) : 10'd0);
        centre_sum = (r_b_top_ok ? 10'(r_win[3]) : 10'd0) + 10'(r_win[4])
                   + (r_b_bot_ok ? 10'(r_win[5]) : 10'd0);
        right_sum  = (r_b_top_ok ? 10'(top_b) : 10'd0) + 10'(mid_b)
                   + (r_b_bot_ok ? 10'(r_b_hv) : 10'd0);
        sum_b = (r_b_left_ok ? SUM_W'(left_sum) : '0) + SUM_W'(centre_sum)
              + (r_b_right_ok ? SUM_W'(right_sum) : '0);

        full_rows = r_b_top_ok && r_b_bot_ok;
        full_cols = r_b_left_ok && r_b_right_ok;
        if (full_rows && full_cols) begin
            recip_b = RECIP_DIV9;
        end else if (full_rows || full_cols) begin
            recip_b = RECIP_DIV6;
        end else begin
            recip_b = RECIP_DIV4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= acc && (pass_take || norm_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_pass     <= pass_mode;
            r_b_emit     <= emit_a;
            r_b_last     <= last_a;
            r_b_addr     <= r_in_col;
            r_b_hv       <= hv_a;
            r_b_ex       <= pass_mode ? (i_extra_channels & EXTRA_MASK) : ex_a;
            r_b_top_ok   <= top_ok_a;
            r_b_bot_ok   <= bot_ok_a;
            r_b_left_ok  <= left_ok_a;
            r_b_right_ok <= right_ok_a;
        end
    end

    // Window and delayed channel bytes advance as each normal word leaves
    // stage B; the frame's final result clears them for the next frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= 8'd0;
            end
            r_hold <= 24'd0;
        end else if (mem_we) begin
            if (r_b_last) begin
                for (int k = 0; k < 6; k++) begin
                    r_win[k] <= 8'd0;
                end
                r_hold <= 24'd0;
            end else begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top_b;
                r_win[4] <= mid_b;
                r_win[5] <= r_b_hv;
                r_hold   <= r_rd_pass;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: mean by reciprocal multiply, then the output register.
    // ------------------------------------------------------------------
    logic               r_c_pass, r_c_last;
    logic [SUM_W-1:0]   r_c_sum;
    logic [RECIP_W-1:0] r_c_recip;
    logic [23:0]        r_c_ex;
    logic [PROD_W-1:0]  prod_c;
    logic [7:0]         value_c;

    assign prod_c  = PROD_W'(r_c_sum) * PROD_W'(r_c_recip);
    assign value_c = r_c_pass ? r_c_sum[7:0] : prod_c[DIV_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid && (r_b_pass || r_b_emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_pass  <= r_b_pass;
            r_c_last  <= r_b_last;
            r_c_sum   <= r_b_pass ? SUM_W'(r_b_hv) : sum_b;
            r_c_recip <= recip_b;
            r_c_ex    <= r_b_pass ? r_b_ex : r_hold;
        end
    end

    logic [7:0]  r_out_value;
    logic [23:0] r_out_ex;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_value <= value_c;
            r_out_ex    <= r_c_ex;
            r_out_last  <= r_c_last;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_smoothed_value     = r_out_value;
    assign o_extra_channels_out = r_out_ex;
    assign o_last_of_frame      = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Within a frame a column is never read while its previous owner is
    // being written; only the frame's final word may overlap the next one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && rd_en && !r_b_last) |-> (r_b_addr != r_in_col))
        else $error("line store read and write hit the same column");

    // The reciprocal multiply always yields an 8-bit mean.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !r_c_pass) |-> (prod_c[PROD_W-1:DIV_SHIFT+8] == '0))
        else $error("mean overflows eight bits");

    // Accepting the word that ends a frame returns all counters to zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (pass_take || norm_take) && last_a) |=>
            (r_in_col == '0 && r_in_row == 17'd0 &&
             r_out_col == '0 && r_out_row == 16'd0))
        else $error("frame counters not restarted after final result");

endmodule
